// File: hdl/ntpbcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpbcd_pkg
// Constants, reciprocal multipliers, result types and the BCD helper for the
// NTP-seconds to BCD real-time-clock date converter.
// ----------------------------------------------------------------------------
package ntpbcd_pkg;

  // seconds from 0000-03-01 to 1900-01-01, i.e. 719468 days * 86400 - 2208988800
  localparam logic [35:0] T_BASE = 36'd59953046400;
  localparam logic signed [17:0] ZONE_STEP = 18'sd3600;

  // day split: t / 86400 = (t >> 7) / 675, 29-bit dividend
  localparam int unsigned DAY_SHIFT = 39;
  localparam logic [29:0] RECIP_DAY = 30'(((64'd1 << 39) + 64'd674) / 64'd675);
  localparam logic [9:0]  DAY_DIV = 10'd675;

  // era boundaries reachable from any 32-bit timestamp and zone offset
  localparam logic [19:0] ERA4_START = 20'd584388;
  localparam logic [19:0] ERA5_START = 20'd730485;
  localparam logic [17:0] DOE_LAST = 18'd146096;

  // weekday: (z + 2) / 7, 21-bit dividend
  localparam int unsigned WEEK_SHIFT = 24;
  localparam logic [21:0] RECIP_WEEK = 22'(((64'd1 << 24) + 64'd6) / 64'd7);

  // doe / 1460 = (doe >> 2) / 365, 16-bit dividend
  localparam int unsigned QUAD_SHIFT = 25;
  localparam logic [16:0] RECIP_QUAD = 17'(((64'd1 << 25) + 64'd364) / 64'd365);

  // year of era: n / 365, 18-bit dividend
  localparam int unsigned YEAR_SHIFT = 27;
  localparam logic [18:0] RECIP_YEAR = 19'(((64'd1 << 27) + 64'd364) / 64'd365);

  // hour: sod / 3600 = (sod >> 4) / 225, 13-bit dividend
  localparam int unsigned HOUR_SHIFT = 21;
  localparam logic [13:0] RECIP_HOUR = 14'(((64'd1 << 21) + 64'd224) / 64'd225);

  // minute: rem / 60 = (rem >> 2) / 15, 10-bit dividend
  localparam int unsigned MIN_SHIFT = 14;
  localparam logic [10:0] RECIP_MIN = 11'(((64'd1 << 14) + 64'd14) / 64'd15);

  localparam logic [11:0] YEAR_LO = 12'd2000;
  localparam logic [11:0] YEAR_HI = 12'd2099;
  localparam logic [11:0] ERA4_YEAR = 12'd1600;
  localparam logic [11:0] ERA5_YEAR = 12'd2000;

  // first day of each month counted from 1 March
  localparam int unsigned MONTHS = 12;
  localparam logic [8:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  typedef struct packed {
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
  } clock_t;

  typedef struct packed {
    logic [2:0] weekday_bcd;
    logic [5:0] day_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
    logic       year_out_of_range;
  } date_t;

  // two BCD digits of a value 0..99, tens by multiply with 205 / 2048
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = 4'(v - 7'(tens) * 7'd10);
    return {tens, ones};
  endfunction

endpackage
`default_nettype wire

// File: hdl/ntpbcd_clock.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpbcd_clock
// Seven-stage pipeline from seconds of day to BCD hour, minute and second.
// ----------------------------------------------------------------------------
module ntpbcd_clock (
  input  wire logic                   clk,
  input  wire logic [16:0]            sod,
  output ntpbcd_pkg::clock_t          clock_out
);

  logic [4:0]  hour_1;
  logic [16:0] sod_1;
  logic [4:0]  hour_2;
  logic [11:0] rem_2;
  logic [4:0]  hour_3;
  logic [5:0]  minute_3;
  logic [11:0] rem_3;
  logic [4:0]  hour_4;
  logic [5:0]  minute_4;
  logic [5:0]  second_4;
  ntpbcd_pkg::clock_t clock_5;
  ntpbcd_pkg::clock_t clock_6;
  ntpbcd_pkg::clock_t clock_7;

  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [7:0]  hour_d;
  logic [7:0]  minute_d;
  logic [7:0]  second_d;

  // hour by reciprocal multiply
  assign hour_prod = 27'(sod[16:4]) * 27'(ntpbcd_pkg::RECIP_HOUR);

  always_ff @(posedge clk) begin
    hour_1 <= hour_prod[ntpbcd_pkg::HOUR_SHIFT +: 5];
    sod_1  <= sod;
  end

  // seconds left within the hour
  always_ff @(posedge clk) begin
    hour_2 <= hour_1;
    rem_2  <= 12'(sod_1 - 17'(hour_1 * 17'd3600));
  end

  // minute by reciprocal multiply
  assign min_prod = 21'(rem_2[11:2]) * 21'(ntpbcd_pkg::RECIP_MIN);

  always_ff @(posedge clk) begin
    hour_3   <= hour_2;
    minute_3 <= min_prod[ntpbcd_pkg::MIN_SHIFT +: 6];
    rem_3    <= rem_2;
  end

  // second is what remains
  always_ff @(posedge clk) begin
    hour_4   <= hour_3;
    minute_4 <= minute_3;
    second_4 <= 6'(rem_3 - 12'(minute_3 * 12'd60));
  end

  // bcd encode
  assign hour_d   = ntpbcd_pkg::to_bcd(7'(hour_4));
  assign minute_d = ntpbcd_pkg::to_bcd(7'(minute_4));
  assign second_d = ntpbcd_pkg::to_bcd(7'(second_4));

  always_ff @(posedge clk) begin
    clock_5.hour_bcd   <= hour_d[5:0];
    clock_5.minute_bcd <= minute_d[6:0];
    clock_5.second_bcd <= second_d[6:0];
  end

  // align with the date pipeline
  always_ff @(posedge clk) begin
    clock_6 <= clock_5;
    clock_7 <= clock_6;
  end

  assign clock_out = clock_7;

endmodule
`default_nettype wire

// File: hdl/ntpbcd_civil.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpbcd_civil
// Seven-stage pipeline from day number (days since 0000-03-01) to weekday,
// day, month and year in BCD, with the year range flag.
// ----------------------------------------------------------------------------
module ntpbcd_civil (
  input  wire logic                   clk,
  input  wire logic [19:0]            z,
  output ntpbcd_pkg::date_t           date_out
);

  // stage 1
  logic        era5_1;
  logic [17:0] doe_1;
  logic [20:0] zp2_1;
  // stage 2
  logic        era5_2;
  logic [17:0] doe_2;
  logic [7:0]  quad_2;
  logic [2:0]  cent_2;
  logic        last_2;
  logic [20:0] zp2_2;
  logic [18:0] wq_2;
  // stage 3
  logic        era5_3;
  logic [17:0] doe_3;
  logic [17:0] n_3;
  logic [2:0]  wday_3;
  // stage 4
  logic        era5_4;
  logic [17:0] doe_4;
  logic [8:0]  yoe_4;
  logic [2:0]  wday_4;
  // stage 5
  logic        era5_5;
  logic [8:0]  yoe_5;
  logic [8:0]  doy_5;
  logic [2:0]  wday_5;
  // stage 6
  logic [4:0]  day_6;
  logic [3:0]  month_6;
  logic [11:0] year_6;
  logic [2:0]  wday_6;
  // stage 7
  ntpbcd_pkg::date_t date_7;

  logic        era5_d;
  logic [42:0] week_prod;
  logic [32:0] quad_prod;
  logic [36:0] year_prod;
  logic [2:0]  wrem;
  logic [1:0]  yoe_cent;
  logic [17:0] yday;
  logic [3:0]  mp;
  logic [11:0] yoff;
  logic        bad;
  logic [7:0]  day_d;
  logic [7:0]  month_d;
  logic [7:0]  year_d;

  // era split, only eras 4 and 5 are reachable
  assign era5_d = (z >= ntpbcd_pkg::ERA5_START);

  always_ff @(posedge clk) begin
    era5_1 <= era5_d;
    doe_1  <= 18'(z - (era5_d ? ntpbcd_pkg::ERA5_START : ntpbcd_pkg::ERA4_START));
    zp2_1  <= 21'(z) + 21'd2;
  end

  // leap corrections and weekday quotient
  assign quad_prod = 33'(doe_1[17:2]) * 33'(ntpbcd_pkg::RECIP_QUAD);
  assign week_prod = 43'(zp2_1) * 43'(ntpbcd_pkg::RECIP_WEEK);

  always_ff @(posedge clk) begin
    era5_2 <= era5_1;
    doe_2  <= doe_1;
    quad_2 <= quad_prod[ntpbcd_pkg::QUAD_SHIFT +: 8];
    cent_2 <= 3'(doe_1 >= 18'd36524) + 3'(doe_1 >= 18'd73048)
            + 3'(doe_1 >= 18'd109572) + 3'(doe_1 >= ntpbcd_pkg::DOE_LAST);
    last_2 <= (doe_1 == ntpbcd_pkg::DOE_LAST);
    zp2_2  <= zp2_1;
    wq_2   <= week_prod[ntpbcd_pkg::WEEK_SHIFT +: 19];
  end

  // day count with leap days removed, weekday remainder
  assign wrem = 3'(zp2_2 - 21'(wq_2 * 21'd7));

  always_ff @(posedge clk) begin
    era5_3 <= era5_2;
    doe_3  <= doe_2;
    n_3    <= doe_2 - 18'(quad_2) + 18'(cent_2) - 18'(last_2);
    wday_3 <= wrem + 3'd1;
  end

  // year of era by reciprocal multiply
  assign year_prod = 37'(n_3) * 37'(ntpbcd_pkg::RECIP_YEAR);

  always_ff @(posedge clk) begin
    era5_4 <= era5_3;
    doe_4  <= doe_3;
    yoe_4  <= year_prod[ntpbcd_pkg::YEAR_SHIFT +: 9];
    wday_4 <= wday_3;
  end

  // day of year from 1 March
  assign yoe_cent = 2'(yoe_4 >= 9'd100) + 2'(yoe_4 >= 9'd200) + 2'(yoe_4 >= 9'd300);
  assign yday = 18'(yoe_4 * 18'd365) + 18'(yoe_4[8:2]) - 18'(yoe_cent);

  always_ff @(posedge clk) begin
    era5_5 <= era5_4;
    yoe_5  <= yoe_4;
    doy_5  <= 9'(doe_4 - yday);
    wday_5 <= wday_4;
  end

  // month index by search of month starts
  always_comb begin
    mp = '0;
    for (int k = 1; k < ntpbcd_pkg::MONTHS; k++) begin
      if (doy_5 >= ntpbcd_pkg::MONTH_START[k]) begin
        mp = 4'(mp + 4'd1);
      end
    end
  end

  assign yoff = era5_5 ? ntpbcd_pkg::ERA5_YEAR : ntpbcd_pkg::ERA4_YEAR;

  always_ff @(posedge clk) begin
    day_6   <= 5'(doy_5 - ntpbcd_pkg::MONTH_START[mp] + 9'd1);
    month_6 <= (mp < 4'd10) ? 4'(mp + 4'd3) : 4'(mp - 4'd9);
    year_6  <= yoff + 12'(yoe_5) + 12'(mp >= 4'd10);
    wday_6  <= wday_5;
  end

  // range check and bcd encode
  assign bad     = (year_6 < ntpbcd_pkg::YEAR_LO) || (year_6 > ntpbcd_pkg::YEAR_HI);
  assign day_d   = ntpbcd_pkg::to_bcd(7'(day_6));
  assign month_d = ntpbcd_pkg::to_bcd(7'(month_6));
  assign year_d  = ntpbcd_pkg::to_bcd(7'(year_6 - ntpbcd_pkg::YEAR_LO));

  always_ff @(posedge clk) begin
    date_7.weekday_bcd       <= wday_6;
    date_7.day_bcd           <= day_d[5:0];
    date_7.month_bcd         <= month_d[4:0];
    date_7.year_bcd          <= bad ? 8'd0 : year_d;
    date_7.year_out_of_range <= bad;
  end

  assign date_out = date_7;

endmodule
`default_nettype wire

// File: hdl/ntp_seconds_to_bcd_rtc_date.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntp_seconds_to_bcd_rtc_date
// Converts NTP seconds plus a whole-hour zone offset to a BCD civil date and
// time for a real-time-clock chip.
// Start to done passes through the ten-stage pipeline.
// Throughput: one word per cycle; busy is always low.
// Results are shown for one cycle under done; the receiver cannot stall.
// Reset clears the valid pipeline and sets the zone offset to 0.
// ----------------------------------------------------------------------------
module ntp_seconds_to_bcd_rtc_date (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        zone_offset_hours_we,
  input  wire logic [4:0]  zone_offset_hours,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] ntp_seconds,
  output logic             done,
  output logic [6:0]       second_bcd,
  output logic [6:0]       minute_bcd,
  output logic [5:0]       hour_bcd,
  output logic [2:0]       weekday_bcd,
  output logic [5:0]       day_bcd,
  output logic [4:0]       month_bcd,
  output logic [7:0]       year_bcd,
  output logic             year_out_of_range
);

  localparam int unsigned DEPTH = 10;

  logic signed [4:0]  zone;
  logic signed [17:0] zone_secs;
  logic [DEPTH-1:0]   vld;
  logic               accept;

  logic [35:0] t_1;
  logic [19:0] q_2;
  logic [28:0] x_2;
  logic [6:0]  low_2;
  logic [19:0] z_3;
  logic [16:0] sod_3;
  logic [58:0] day_prod;
  logic [9:0]  rem_d;

  ntpbcd_pkg::clock_t clock_res;
  ntpbcd_pkg::date_t  date_res;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (zone_offset_hours_we) begin
      zone <= zone_offset_hours;
    end
  end

  // valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], accept};
    end
  end

  // seconds since 0000-03-01
  assign zone_secs = zone * ntpbcd_pkg::ZONE_STEP;

  always_ff @(posedge clk) begin
    t_1 <= {4'd0, ntp_seconds} + ntpbcd_pkg::T_BASE + 36'(zone_secs);
  end

  // day number by reciprocal multiply
  assign day_prod = 59'(t_1[35:7]) * 59'(ntpbcd_pkg::RECIP_DAY);

  always_ff @(posedge clk) begin
    q_2   <= day_prod[ntpbcd_pkg::DAY_SHIFT +: 20];
    x_2   <= t_1[35:7];
    low_2 <= t_1[6:0];
  end

  // seconds of day from the remainder
  assign rem_d = x_2[9:0] - 10'(q_2 * 30'(ntpbcd_pkg::DAY_DIV));

  always_ff @(posedge clk) begin
    z_3   <= q_2;
    sod_3 <= {rem_d, low_2};
  end

  ntpbcd_clock u_clock (
    .clk       (clk),
    .sod       (sod_3),
    .clock_out (clock_res)
  );

  ntpbcd_civil u_civil (
    .clk      (clk),
    .z        (z_3),
    .date_out (date_res)
  );

  // result word
  assign done              = vld[DEPTH-1];
  assign second_bcd        = clock_res.second_bcd;
  assign minute_bcd        = clock_res.minute_bcd;
  assign hour_bcd          = clock_res.hour_bcd;
  assign weekday_bcd       = date_res.weekday_bcd;
  assign day_bcd           = date_res.day_bcd;
  assign month_bcd         = date_res.month_bcd;
  assign year_bcd          = date_res.year_bcd;
  assign year_out_of_range = date_res.year_out_of_range;

endmodule
`default_nettype wire
